// File: rtl/core/mm_pkg.sv
// Shared types, codes and arithmetic helpers for the matrix multiply core.
// No dependencies; imported by mm_front, mm_back and matrix_multiply_core.
package mm_pkg;

    // Request codes carried on the input channel.
    typedef enum logic [1:0] {
        REQ_WR_A    = 2'd0,
        REQ_WR_B    = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS  = 2'd1;
    localparam logic [1:0] CFG_INNER_LEN = 2'd2;

    localparam logic [3:0] DIM_RESET = 4'd8;

    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // Classified command passed from front to back.
    typedef struct packed {
        t_req               op;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } t_cmd;

    // Dimensions in use, already clamped to 1..MAX_DIM.
    typedef struct packed {
        logic [3:0] m;
        logic [3:0] n;
        logic [3:0] kl;
    } t_dims;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT
    } t_back_state;

    // Zero counts as one, anything above the limit counts as the limit.
    function automatic logic [3:0] dim_used(input logic [3:0] value, input logic [3:0] limit);
        logic [3:0] res;
        if (value == 4'd0) begin
            res = 4'd1;
        end else if (value > limit) begin
            res = limit;
        end else begin
            res = value;
        end
        return res;
    endfunction

    // Signed 64-bit add, clamped to the signed range on overflow.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/matrix_multiply_core.sv
// Top level of the integer matrix multiply core: C = A * B, up to MAX_DIM square.
// Depends on mm_pkg, mm_front and mm_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_stall| i_req_type, i_row_index, i_col_index,
//           |                        | i_elem_value
//  result   | o_out_valid/i_out_stall| o_out_row, o_out_col, o_product_value, o_last
//  config   | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
//  Flow: the front takes one input transfer per cycle while its two-entry queue
//  has room. In the back a write completes in the idle state; a compute walks one
//  element at a time through the single multiply-accumulate pipeline (address,
//  store read, multiply, accumulate), finishing each element before the next.
//  Reset: synchronous, active low; clears queue, sequencer and valid flags,
//  sets all three dimensions to 8. Element stores are not cleared.
//  Stalls: a stalled result holds in the output register; the back waits for it
//  before the next element is emitted, and the queue fills and raises o_in_stall.
module matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_elem_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [63:0] o_product_value,
    output logic               o_last,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);
    import mm_pkg::*;

    logic [3:0] r_num_rows;
    logic [3:0] r_num_cols;
    logic [3:0] r_inner_len;

    t_dims w_dims;
    logic  w_cmd_valid;
    t_cmd  w_cmd;
    logic  w_cmd_pop;

    // Keep the written bits; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= DIM_RESET;
            r_num_cols  <= DIM_RESET;
            r_inner_len <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_ROWS:  r_num_rows  <= i_cfg_data;
                CFG_NUM_COLS:  r_num_cols  <= i_cfg_data;
                CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                default:       r_num_rows  <= r_num_rows;
            endcase
        end
    end

    // Clamp each dimension into 1..MAX_DIM; the back latches them at compute start.
    assign w_dims.m  = dim_used(r_num_rows,  4'(MAX_DIM));
    assign w_dims.n  = dim_used(r_num_cols,  4'(MAX_DIM));
    assign w_dims.kl = dim_used(r_inner_len, 4'(MAX_DIM));

    // Front: drop unknown requests and out-of-range writes, queue the rest in order.
    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    // Back: perform writes, walk C column by column, row within column.
    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dims          (w_dims),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

endmodule

// File: rtl/core/mm_front.sv
// Front end: accepts input transfers, drops ignored requests, queues commands.
// Depends on mm_pkg for t_cmd and request codes.
module mm_front #(
    parameter int MAX_DIM = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_req_type,
    input  logic [2:0]    i_row_index,
    input  logic [2:0]    i_col_index,
    input  logic [31:0]   i_elem_value,
    output logic          o_cmd_valid,
    output mm_pkg::t_cmd  o_cmd,
    input  logic          i_cmd_pop
);
    import mm_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    logic in_range;
    logic keep;
    logic push;
    logic pop;
    t_cmd w_cmd;

    assign in_range = (4'(i_row_index) < 4'(MAX_DIM)) && (4'(i_col_index) < 4'(MAX_DIM));

    always_comb begin
        case (i_req_type)
            REQ_WR_A:    keep = in_range;
            REQ_WR_B:    keep = in_range;
            REQ_COMPUTE: keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign w_cmd.op    = t_req'(i_req_type);
    assign w_cmd.row   = i_row_index;
    assign w_cmd.col   = i_col_index;
    assign w_cmd.value = $signed(i_elem_value);

    assign o_in_stall  = (r_count == 2'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: rtl/core/mm_back.sv
// Back end: element stores, multiply-accumulate pipeline and result register.
// Depends on mm_pkg for t_cmd, t_dims, t_back_state and sat_add.
module mm_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mm_pkg::t_dims       i_dims,
    input  logic                i_cmd_valid,
    input  mm_pkg::t_cmd        i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_out_row,
    output logic [2:0]          o_out_col,
    output logic signed [63:0]  o_product_value,
    output logic                o_last
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0] r_a_mem [DEPTH];
    logic signed [31:0] r_b_mem [DEPTH];

    t_back_state r_state;
    t_back_state n_state;

    t_dims      r_dims;
    logic [2:0] r_row;
    logic [2:0] r_col;
    logic [2:0] r_j;

    // pipeline
    logic signed [31:0] r_a_q;
    logic signed [31:0] r_b_q;
    logic               r_p1_vld;
    logic               r_p1_first;
    logic               r_p1_last;
    logic signed [63:0] r_prod;
    logic               r_p2_vld;
    logic               r_p2_first;
    logic               r_p2_last;
    logic signed [63:0] r_acc;
    logic               r_acc_done;

    logic               r_out_valid;
    logic [2:0]         r_out_row;
    logic [2:0]         r_out_col;
    logic signed [63:0] r_out_value;
    logic               r_out_last;

    logic w_we_a;
    logic w_we_b;
    logic w_start;
    logic w_issue;
    logic w_emit;
    logic w_last_j;
    logic w_last_row;
    logic w_last_elem;
    logic w_out_free;

    logic [6:0]         w_wr_full;
    logic [6:0]         w_a_rd_full;
    logic [6:0]         w_b_rd_full;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_a_rd_addr;
    logic [AW-1:0]      w_b_rd_addr;
    logic signed [63:0] w_prod;

    assign w_wr_full   = 7'(i_cmd.row) * 7'(MAX_DIM) + 7'(i_cmd.col);
    assign w_a_rd_full = 7'(r_row) * 7'(MAX_DIM) + 7'(r_j);
    assign w_b_rd_full = 7'(r_j) * 7'(MAX_DIM) + 7'(r_col);
    assign w_wr_addr   = w_wr_full[AW-1:0];
    assign w_a_rd_addr = w_a_rd_full[AW-1:0];
    assign w_b_rd_addr = w_b_rd_full[AW-1:0];

    assign w_last_j    = (4'(r_j) + 4'd1 == r_dims.kl);
    assign w_last_row  = (4'(r_row) + 4'd1 == r_dims.m);
    assign w_last_elem = w_last_row && (4'(r_col) + 4'd1 == r_dims.n);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && i_cmd.op == REQ_COMPUTE) begin
                    n_state = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (w_last_j) begin
                    n_state = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (r_acc_done && w_out_free) begin
                    n_state = w_last_elem ? BK_IDLE : BK_ISSUE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        w_we_a    = 1'b0;
        w_we_b    = 1'b0;
        w_start   = 1'b0;
        w_issue   = 1'b0;
        w_emit    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        REQ_WR_A:    w_we_a  = 1'b1;
                        REQ_WR_B:    w_we_b  = 1'b1;
                        REQ_COMPUTE: w_start = 1'b1;
                        default:     w_start = 1'b0;
                    endcase
                end
            end
            BK_ISSUE: w_issue = 1'b1;
            BK_WAIT:  w_emit  = r_acc_done && w_out_free;
            default:  w_issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_a_mem[w_wr_addr] <= i_cmd.value;
        end
        if (w_we_b) begin
            r_b_mem[w_wr_addr] <= i_cmd.value;
        end
        r_a_q <= r_a_mem[w_a_rd_addr];
        r_b_q <= r_b_mem[w_b_rd_addr];
    end

    assign w_prod = r_a_q * r_b_q;

    // payload: counters, products, accumulator, result
    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_j == 3'd0);
        r_p1_last  <= w_last_j;
        r_prod     <= w_prod;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        if (r_p2_vld) begin
            r_acc <= sat_add(r_p2_first ? 64'sd0 : r_acc, r_prod);
        end
        if (w_start) begin
            r_dims <= i_dims;
            r_row  <= 3'd0;
            r_col  <= 3'd0;
            r_j    <= 3'd0;
        end
        if (w_issue) begin
            r_j <= w_last_j ? 3'd0 : r_j + 3'd1;
        end
        if (w_emit) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_value <= r_acc;
            r_out_last  <= w_last_elem;
            if (w_last_row) begin
                r_row <= 3'd0;
                r_col <= r_col + 3'd1;
            end else begin
                r_row <= r_row + 3'd1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= w_issue;
            r_p2_vld <= r_p1_vld;
            if (r_p2_vld && r_p2_last) begin
                r_acc_done <= 1'b1;
            end else if (w_emit) begin
                r_acc_done <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

endmodule
